@@ design/msh_pkg.sv @@
// Shared constants and types for the stereo mid/side histogram.
package msh_pkg;

  localparam int unsigned SAMPLE_W = 32;
  localparam int unsigned COUNT_W = 32;
  localparam int unsigned POWER_W = 6;
  localparam int unsigned HIST_MAX = 4;
  localparam int unsigned CFG_INDEX_W = 3;

  localparam int unsigned NUM_BINS_DEF = 256;
  localparam int unsigned HIST_COUNT_DEF = 4;

  localparam logic [CFG_INDEX_W-1:0] CFG_LO_BOUND = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_HI_BOUND = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_BIN_SHIFT = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] CFG_STEREO_MODE = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] CFG_CHANNEL_ENABLE = 3'd4;

  localparam logic FUNC_ADD = 1'b0;
  localparam logic FUNC_READ = 1'b1;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] lo_bound;
    logic signed [SAMPLE_W-1:0] hi_bound;
    logic [POWER_W-1:0]         bin_shift;
    logic                       stereo_mode;
    logic [HIST_MAX-1:0]        channel_enable;
  } cfg_t;

  typedef struct packed {
    logic clear;
    logic calc;
    logic rd;
    logic wr;
    logic ext_addr;
  } lane_cmd_t;

endpackage

@@ design/stereo_mid_side_histogram.sv @@
// Top level of the stereo mid/side histogram with one lane per histogram.
// After reset the block clears its bin memories, stepping through every bin address, before
// it takes the first request; configuration writes are taken at any time. Requests are
// handled one at a time: an add request passes the sum stage, binning in the lanes, memory
// read, increment write with merge and output before its result is valid, and a read request
// passes memory read, merge and output only. Each lane memory has one read and one write
// port, used in turn. The result waits in an output register while the next request is
// accepted, so the next request can be taken in the cycle in which the result appears. A
// new result that finds the output register still full waits until it drains, and the
// input stays blocked until then.
module stereo_mid_side_histogram #(
  parameter int unsigned NUM_BINS = msh_pkg::NUM_BINS_DEF,
  parameter int unsigned HIST_COUNT = msh_pkg::HIST_COUNT_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [msh_pkg::CFG_INDEX_W-1:0]     cfg_index_i,
  input  logic [msh_pkg::SAMPLE_W-1:0]        cfg_wdata_i,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic                                func_i,
  input  logic signed [msh_pkg::SAMPLE_W-1:0] left_i,
  input  logic signed [msh_pkg::SAMPLE_W-1:0] right_i,
  input  logic [1:0]                          hist_select_i,
  input  logic [7:0]                          bin_index_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic [msh_pkg::COUNT_W-1:0]         count_o,
  output logic [msh_pkg::HIST_MAX-1:0]        counted_mask_o
);
  import msh_pkg::*;

  localparam int unsigned BinW = $clog2(NUM_BINS);
  localparam logic [BinW-1:0] LastAddr = BinW'(NUM_BINS - 1);

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SUMS,
    ST_CALC,
    ST_READ,
    ST_INCR,
    ST_DONE
  } state_e;

  state_e                      state_q;
  cfg_t                        cfg_q;
  logic [BinW-1:0]             clr_addr_q;
  logic                        func_q;
  logic signed [SAMPLE_W-1:0]  left_q, right_q, mid_q, diff_q;
  logic [1:0]                  sel_q;
  logic [7:0]                  idx_q;
  logic                        out_valid_q;
  logic [COUNT_W-1:0]          count_q;
  logic [HIST_MAX-1:0]         mask_q;

  logic [SAMPLE_W:0]           sum_x, dif_x, sum_adj, dif_adj;
  logic signed [SAMPLE_W-1:0]  samples [HIST_MAX];
  lane_cmd_t                   cmd;
  logic [BinW-1:0]             lane_addr;
  logic                        idx_ok;
  logic [HIST_COUNT-1:0]       hits;
  logic [HIST_COUNT-1:0][COUNT_W-1:0] rd_data;
  logic [COUNT_W-1:0]          merge_count;
  logic [HIST_MAX-1:0]         merge_mask;

  assign sum_x = {left_q[SAMPLE_W-1], left_q} + {right_q[SAMPLE_W-1], right_q};
  assign dif_x = {left_q[SAMPLE_W-1], left_q} - {right_q[SAMPLE_W-1], right_q};
  assign sum_adj = sum_x + (SAMPLE_W+1)'(sum_x[SAMPLE_W]);
  assign dif_adj = dif_x + (SAMPLE_W+1)'(dif_x[SAMPLE_W]);

  assign samples[0] = left_q;
  assign samples[1] = right_q;
  assign samples[2] = mid_q;
  assign samples[3] = diff_q;

  assign cmd.clear = (state_q == ST_CLEAR);
  assign cmd.calc = (state_q == ST_CALC);
  assign cmd.rd = (state_q == ST_READ);
  assign cmd.wr = (state_q == ST_INCR) && (func_q == FUNC_ADD);
  assign cmd.ext_addr = (func_q == FUNC_READ);

  assign lane_addr = (state_q == ST_CLEAR) ? clr_addr_q : BinW'(idx_q);
  assign idx_ok = (32'(idx_q) < NUM_BINS);

  for (genvar h = 0; h < HIST_COUNT; h++) begin : g_lane
    logic lane_en;
    if (h == 0) begin : g_left
      assign lane_en = cfg_q.channel_enable[h];
    end else begin : g_other
      assign lane_en = cfg_q.channel_enable[h] && cfg_q.stereo_mode;
    end

    msh_lane #(
      .NUM_BINS(NUM_BINS)
    ) u_lane (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .cmd_i      (cmd),
      .en_i       (lane_en),
      .sample_i   (samples[h]),
      .lo_bound_i (cfg_q.lo_bound),
      .hi_bound_i (cfg_q.hi_bound),
      .bin_shift_i(cfg_q.bin_shift),
      .addr_i     (lane_addr),
      .hit_o      (hits[h]),
      .rd_data_o  (rd_data[h])
    );
  end

  msh_merge #(
    .HIST_COUNT(HIST_COUNT)
  ) u_merge (
    .clk_i    (clk_i),
    .load_i   (state_q == ST_INCR),
    .func_i   (func_q),
    .sel_i    (sel_q),
    .idx_ok_i (idx_ok),
    .hit_i    (hits),
    .rd_data_i(rd_data),
    .count_o  (merge_count),
    .mask_o   (merge_mask)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
      cfg_q.lo_bound <= -32'sd32768;
      cfg_q.hi_bound <= 32'sd32767;
      cfg_q.bin_shift <= POWER_W'(8);
      cfg_q.stereo_mode <= 1'b1;
      cfg_q.channel_enable <= '1;
      clr_addr_q <= '0;
      func_q <= FUNC_ADD;
      left_q <= '0;
      right_q <= '0;
      mid_q <= '0;
      diff_q <= '0;
      sel_q <= '0;
      idx_q <= '0;
      out_valid_q <= 1'b0;
      count_q <= '0;
      mask_q <= '0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          CFG_LO_BOUND:       cfg_q.lo_bound <= cfg_wdata_i;
          CFG_HI_BOUND:       cfg_q.hi_bound <= cfg_wdata_i;
          CFG_BIN_SHIFT:      cfg_q.bin_shift <= cfg_wdata_i[POWER_W-1:0];
          CFG_STEREO_MODE:    cfg_q.stereo_mode <= cfg_wdata_i[0];
          CFG_CHANNEL_ENABLE: cfg_q.channel_enable <= cfg_wdata_i[HIST_MAX-1:0];
          default: ;
        endcase
      end

      if (out_valid_q && out_ready_i && (state_q != ST_DONE)) begin
        out_valid_q <= 1'b0;
      end

      case (state_q)
        ST_CLEAR: begin
          clr_addr_q <= clr_addr_q + BinW'(1);
          if (clr_addr_q == LastAddr) begin
            state_q <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (in_valid_i) begin
            func_q <= func_i;
            left_q <= left_i;
            right_q <= right_i;
            sel_q <= hist_select_i;
            idx_q <= bin_index_i;
            state_q <= (func_i == FUNC_READ) ? ST_READ : ST_SUMS;
          end
        end
        ST_SUMS: begin
          mid_q <= sum_adj[SAMPLE_W:1];
          diff_q <= dif_adj[SAMPLE_W:1];
          state_q <= ST_CALC;
        end
        ST_CALC: state_q <= ST_READ;
        ST_READ: state_q <= ST_INCR;
        ST_INCR: state_q <= ST_DONE;
        ST_DONE: begin
          if (!out_valid_q || out_ready_i) begin
            out_valid_q <= 1'b1;
            count_q <= merge_count;
            mask_q <= merge_mask;
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign in_ready_o = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign count_o = count_q;
  assign counted_mask_o = mask_q;

  a_mask_or_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (counted_mask_o != '0)) |-> (count_o == '0))
    else $error("result carries both a count and a counted mask");

  a_mono_left_only: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !cfg_q.stereo_mode) |-> (counted_mask_o[HIST_MAX-1:1] == '0))
    else $error("mono mode counted a histogram other than left");

  a_mask_in_lanes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ((counted_mask_o >> HIST_COUNT) == '0))
    else $error("counted mask names a histogram that does not exist");

  a_incr_after_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_INCR) |-> ($past(state_q) == ST_READ))
    else $error("increment written without a preceding memory read");

endmodule

@@ design/msh_lane.sv @@
// One histogram lane: bins a sample and keeps its bin counts in a local memory.
module msh_lane #(
  parameter int unsigned NUM_BINS = msh_pkg::NUM_BINS_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  msh_pkg::lane_cmd_t                  cmd_i,
  input  logic                                en_i,
  input  logic signed [msh_pkg::SAMPLE_W-1:0] sample_i,
  input  logic signed [msh_pkg::SAMPLE_W-1:0] lo_bound_i,
  input  logic signed [msh_pkg::SAMPLE_W-1:0] hi_bound_i,
  input  logic [msh_pkg::POWER_W-1:0]         bin_shift_i,
  input  logic [$clog2(NUM_BINS)-1:0]         addr_i,
  output logic                                hit_o,
  output logic [msh_pkg::COUNT_W-1:0]         rd_data_o
);
  import msh_pkg::*;

  localparam int unsigned BinW = $clog2(NUM_BINS);
  localparam logic [SAMPLE_W:0] BinLimit = (SAMPLE_W+1)'(NUM_BINS);

  logic [COUNT_W-1:0] mem [NUM_BINS];
  logic [SAMPLE_W:0]  offset;
  logic [SAMPLE_W:0]  shifted;
  logic               hit_d, hit_q;
  logic [BinW-1:0]    bin_q;
  logic [BinW-1:0]    rd_addr, wr_addr;
  logic [COUNT_W-1:0] rd_data_q, wr_data;
  logic               wr_en;

  assign offset = {sample_i[SAMPLE_W-1], sample_i} - {lo_bound_i[SAMPLE_W-1], lo_bound_i};
  assign shifted = offset >> bin_shift_i;
  assign hit_d = en_i && (sample_i >= lo_bound_i) && (sample_i <= hi_bound_i) &&
                 (shifted < BinLimit);

  assign rd_addr = cmd_i.ext_addr ? addr_i : bin_q;
  assign wr_addr = cmd_i.clear ? addr_i : bin_q;
  assign wr_data = cmd_i.clear ? '0 : rd_data_q + COUNT_W'(1);
  assign wr_en = cmd_i.clear || (cmd_i.wr && hit_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hit_q <= 1'b0;
    end else if (cmd_i.calc) begin
      hit_q <= hit_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.calc) begin
      bin_q <= shifted[BinW-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (cmd_i.rd) begin
      rd_data_q <= mem[rd_addr];
    end
  end

  assign hit_o = hit_q;
  assign rd_data_o = rd_data_q;

endmodule

@@ design/msh_merge.sv @@
// Merging stage: gathers lane hits into the counted mask and selects a read count.
module msh_merge #(
  parameter int unsigned HIST_COUNT = msh_pkg::HIST_COUNT_DEF
) (
  input  logic                                       clk_i,
  input  logic                                       load_i,
  input  logic                                       func_i,
  input  logic [1:0]                                 sel_i,
  input  logic                                       idx_ok_i,
  input  logic [HIST_COUNT-1:0]                      hit_i,
  input  logic [HIST_COUNT-1:0][msh_pkg::COUNT_W-1:0] rd_data_i,
  output logic [msh_pkg::COUNT_W-1:0]                count_o,
  output logic [msh_pkg::HIST_MAX-1:0]               mask_o
);
  import msh_pkg::*;

  logic [COUNT_W-1:0]  count_d, count_q;
  logic [HIST_MAX-1:0] mask_d, mask_q;

  always_comb begin
    count_d = '0;
    mask_d = '0;
    for (int h = 0; h < HIST_COUNT; h++) begin
      if (func_i == FUNC_READ) begin
        if (idx_ok_i && (sel_i == 2'(h))) begin
          count_d = rd_data_i[h];
        end
      end else begin
        mask_d[h] = hit_i[h];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      count_q <= count_d;
      mask_q <= mask_d;
    end
  end

  assign count_o = count_q;
  assign mask_o = mask_q;

endmodule
